/* rtl/issue_scoreboard_hazard_check_core_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the issue scoreboard
// Clocked assertion wrappers that compile to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef ISSUE_SCOREBOARD_HAZARD_CHECK_CORE_MACROS_SVH
`define ISSUE_SCOREBOARD_HAZARD_CHECK_CORE_MACROS_SVH

`ifndef SYNTHESIS

// check a property on every clock edge outside reset
`define ISC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// check a property on every clock edge, reset included
`define ISC_ASSERT_RST(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`else

`define ISC_ASSERT(label, prop, msg)
`define ISC_ASSERT_RST(label, prop, msg)

`endif

`endif

/* rtl/isc_pkg.sv */
// ----------------------------------------------------------------------------
// Issue scoreboard package
// Widths, register and service codes, instruction classes and shared types.
// ----------------------------------------------------------------------------
package isc_pkg;

   // pending-write counter width and saturation value
   localparam int COUNT_WIDTH = 3;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
   localparam logic [COUNT_WIDTH-1:0] COUNT_ZERO = '0;

   // general register file
   localparam int GPR_COUNT = 32;
   localparam int GPR_IDX_WIDTH = 5;
   localparam int SLOT_IDX_WIDTH = 6;

   // slot and register codes
   localparam logic [SLOT_IDX_WIDTH-1:0] SLOT_LO = 6'd32;
   localparam logic [SLOT_IDX_WIDTH-1:0] SLOT_HI = 6'd33;
   localparam logic [GPR_IDX_WIDTH-1:0] REG_V0 = 5'd2;
   localparam logic [GPR_IDX_WIDTH-1:0] REG_A0 = 5'd4;

   // syscall service codes
   localparam logic [31:0] SVC_PRINT_INT = 32'd1;
   localparam logic [31:0] SVC_PRINT_STR = 32'd4;
   localparam logic [31:0] SVC_READ_INT = 32'd5;
   localparam logic [31:0] SVC_READ_STR = 32'd8;
   localparam logic [31:0] SVC_SBRK = 32'd9;
   localparam logic [31:0] SVC_EXIT = 32'd10;
   localparam logic [31:0] SVC_EXIT_CODE = 32'd17;

   typedef logic [COUNT_WIDTH-1:0] count_type;

   typedef enum logic {
      KIND_ISSUE = 1'b0,
      KIND_RETIRE = 1'b1
   } kind_type;

   typedef enum logic [3:0] {
      CLS_ALU3 = 4'd0,
      CLS_MULT = 4'd1,
      CLS_NEG = 4'd2,
      CLS_LI = 4'd3,
      CLS_JUMP = 4'd4,
      CLS_BEQ = 4'd5,
      CLS_BEQZ = 4'd6,
      CLS_LA = 4'd7,
      CLS_STORE = 4'd8,
      CLS_MFHILO = 4'd9,
      CLS_NOP = 4'd10,
      CLS_SYSCALL = 4'd11
   } op_class_type;

   // scoreboard update decided for one request
   typedef struct packed {
      logic hazard;
      logic fetch_stop;
      logic count_down;
      logic gpr_en;
      logic lo_en;
      logic hi_en;
   } update_type;

   // general register whose counter a request may change
   function automatic logic [GPR_IDX_WIDTH-1:0] update_reg(
      input logic kind,
      input logic [3:0] op_class,
      input logic [GPR_IDX_WIDTH-1:0] first_reg,
      input logic [SLOT_IDX_WIDTH-1:0] retire_index
   );
      logic [GPR_IDX_WIDTH-1:0] idx;
      if (kind == KIND_RETIRE) begin
         idx = retire_index[GPR_IDX_WIDTH-1:0];
      end else if (op_class == CLS_SYSCALL) begin
         idx = REG_V0;
      end else begin
         idx = first_reg;
      end
      return idx;
   endfunction

   // saturating step of one counter
   function automatic count_type count_step(input count_type cnt, input logic down);
      count_type res;
      if (down) begin
         res = (cnt == COUNT_ZERO) ? COUNT_ZERO : cnt - 1'b1;
      end else begin
         res = (cnt == COUNT_MAX) ? COUNT_MAX : cnt + 1'b1;
      end
      return res;
   endfunction

endpackage

/* rtl/isc_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data (read-first).
// ----------------------------------------------------------------------------
module isc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/isc_decode.sv */
// ----------------------------------------------------------------------------
// Issue scoreboard decode
// Checks the sources of one request against the busy flags and picks the
// counters to change.
// ----------------------------------------------------------------------------
module isc_decode
   import isc_pkg::*;
(
   input  logic                      kind,
   input  logic [3:0]                op_class,
   input  logic [GPR_IDX_WIDTH-1:0]  first_reg,
   input  logic [GPR_IDX_WIDTH-1:0]  second_reg,
   input  logic [GPR_IDX_WIDTH-1:0]  third_reg,
   input  logic                      first_is_reg,
   input  logic                      second_is_reg,
   input  logic                      third_is_reg,
   input  logic                      second_is_offset,
   input  logic                      from_lo,
   input  logic [31:0]               service_code,
   input  logic [SLOT_IDX_WIDTH-1:0] retire_index,
   input  logic [GPR_COUNT-1:0]      gpr_busy,
   input  logic                      lo_busy,
   input  logic                      hi_busy,
   output update_type                upd
);

   logic busy1;
   logic busy2;
   logic busy3;
   logic svc_needs_a0;
   logic svc_exit;
   logic svc_reads;

   assign busy1 = gpr_busy[first_reg];
   assign busy2 = gpr_busy[second_reg];
   assign busy3 = gpr_busy[third_reg];

   // classify the syscall service
   assign svc_needs_a0 = (service_code == SVC_PRINT_INT) || (service_code == SVC_PRINT_STR) ||
                         (service_code == SVC_READ_STR) || (service_code == SVC_SBRK);
   assign svc_exit = (service_code == SVC_EXIT) || (service_code == SVC_EXIT_CODE);
   assign svc_reads = (service_code == SVC_READ_INT) || (service_code == SVC_SBRK);

   // decide hazard and counter updates
   always_comb begin
      upd = '0;
      if (kind == KIND_RETIRE) begin
         upd.count_down = 1'b1;
         upd.gpr_en = ~retire_index[SLOT_IDX_WIDTH-1];
         upd.lo_en = (retire_index == SLOT_LO);
         upd.hi_en = (retire_index == SLOT_HI);
      end else begin
         case (op_class_type'(op_class))
            CLS_ALU3: begin
               upd.hazard = busy2 || (third_is_reg && busy3);
               upd.gpr_en = ~upd.hazard;
            end
            CLS_MULT: begin
               upd.hazard = busy1 || (second_is_reg && busy2);
               upd.lo_en = ~upd.hazard;
               upd.hi_en = ~upd.hazard;
            end
            CLS_NEG: begin
               upd.hazard = busy2;
               upd.gpr_en = ~upd.hazard;
            end
            CLS_LI: begin
               upd.gpr_en = 1'b1;
            end
            CLS_JUMP: begin
               upd.hazard = first_is_reg && busy1;
            end
            CLS_BEQ: begin
               upd.hazard = busy1 || (second_is_reg && busy2);
            end
            CLS_BEQZ, CLS_STORE: begin
               upd.hazard = busy1;
            end
            CLS_LA: begin
               upd.hazard = second_is_offset && busy3;
               upd.gpr_en = ~upd.hazard;
            end
            CLS_MFHILO: begin
               upd.hazard = from_lo ? lo_busy : hi_busy;
               upd.gpr_en = ~upd.hazard;
            end
            CLS_SYSCALL: begin
               upd.hazard = gpr_busy[REG_V0] || (svc_needs_a0 && gpr_busy[REG_A0]);
               upd.fetch_stop = ~upd.hazard && svc_exit;
               upd.gpr_en = ~upd.hazard && svc_reads;
            end
            default: begin
               upd = '0;
            end
         endcase
      end
   end

endmodule

/* rtl/issue_scoreboard_hazard_check_core.sv */
// ----------------------------------------------------------------------------
// Issue scoreboard hazard check
// Pending-write scoreboard for 32 general registers plus lo and hi: flags
// source hazards on issue, counts destinations up and retires count down.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  req       in         req_valid/req_stall  kind, class, operands, service, retire slot
//  rsp       out        rsp_valid/rsp_stall  hazard, fetch_stop
//
// One request per cycle while rsp is not stalled; an accepted request passes
// the input register (with counter RAM read), then the result register.
// The general counters sit in a 32-entry RAM read at acceptance; the last
// write is forwarded so back-to-back requests on one register see it.
// Reset clears the busy flags and the lo/hi counters; no clearing pass.
// A stalled result holds the input register, which then stalls req.
// ----------------------------------------------------------------------------
`include "issue_scoreboard_hazard_check_core_macros.svh"

module issue_scoreboard_hazard_check_core
   import isc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_kind,
   input  logic [3:0]  req_op_class,
   input  logic [4:0]  req_first_reg,
   input  logic [4:0]  req_second_reg,
   input  logic [4:0]  req_third_reg,
   input  logic        req_first_is_reg,
   input  logic        req_second_is_reg,
   input  logic        req_third_is_reg,
   input  logic        req_second_is_offset,
   input  logic        req_from_lo,
   input  logic [31:0] req_service_code,
   input  logic [5:0]  req_retire_index,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_hazard,
   output logic        rsp_fetch_stop
);

   logic req_accept;
   logic advance;
   logic process;
   logic [GPR_IDX_WIDTH-1:0] rd_reg;

   // input register
   logic s1_valid_ff;
   logic s1_kind_ff;
   logic [3:0] s1_op_class_ff;
   logic [GPR_IDX_WIDTH-1:0] s1_first_reg_ff;
   logic [GPR_IDX_WIDTH-1:0] s1_second_reg_ff;
   logic [GPR_IDX_WIDTH-1:0] s1_third_reg_ff;
   logic s1_first_is_reg_ff;
   logic s1_second_is_reg_ff;
   logic s1_third_is_reg_ff;
   logic s1_second_is_offset_ff;
   logic s1_from_lo_ff;
   logic [31:0] s1_service_code_ff;
   logic [SLOT_IDX_WIDTH-1:0] s1_retire_index_ff;
   logic [GPR_IDX_WIDTH-1:0] s1_upd_reg_ff;

   // scoreboard state
   logic [GPR_COUNT-1:0] busy_ff;
   logic [GPR_COUNT-1:0] busy_in;
   count_type lo_cnt_ff;
   count_type lo_cnt_in;
   count_type hi_cnt_ff;
   count_type hi_cnt_in;
   logic fwd_valid_ff;
   logic [GPR_IDX_WIDTH-1:0] fwd_addr_ff;
   count_type fwd_data_ff;

   // result register
   logic rsp_valid_ff;
   logic rsp_valid_in;
   logic rsp_hazard_ff;
   logic rsp_fetch_stop_ff;

   count_type ram_rd_data;
   count_type gpr_raw;
   count_type gpr_cnt;
   count_type gpr_new;
   logic gpr_wr;
   update_type upd;

   // handshake
   assign advance = ~rsp_valid_ff | ~rsp_stall;
   assign process = s1_valid_ff & advance;
   assign req_stall = s1_valid_ff & ~advance;
   assign req_accept = req_valid & ~req_stall;
   assign rd_reg = update_reg(req_kind, req_op_class, req_first_reg, req_retire_index);

   // capture request and the register it may update; hold a stalled one
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= req_accept | req_stall;
      end
      if (req_accept) begin
         s1_kind_ff <= req_kind;
         s1_op_class_ff <= req_op_class;
         s1_first_reg_ff <= req_first_reg;
         s1_second_reg_ff <= req_second_reg;
         s1_third_reg_ff <= req_third_reg;
         s1_first_is_reg_ff <= req_first_is_reg;
         s1_second_is_reg_ff <= req_second_is_reg;
         s1_third_is_reg_ff <= req_third_is_reg;
         s1_second_is_offset_ff <= req_second_is_offset;
         s1_from_lo_ff <= req_from_lo;
         s1_service_code_ff <= req_service_code;
         s1_retire_index_ff <= req_retire_index;
         s1_upd_reg_ff <= rd_reg;
      end
   end

   isc_ram #(
      .WIDTH (COUNT_WIDTH),
      .DEPTH (GPR_COUNT)
   ) u_count_ram (
      .clock   (clock),
      .wr_en   (gpr_wr),
      .wr_addr (s1_upd_reg_ff),
      .wr_data (gpr_new),
      .rd_en   (req_accept),
      .rd_addr (rd_reg),
      .rd_data (ram_rd_data)
   );

   isc_decode u_decode (
      .kind             (s1_kind_ff),
      .op_class         (s1_op_class_ff),
      .first_reg        (s1_first_reg_ff),
      .second_reg       (s1_second_reg_ff),
      .third_reg        (s1_third_reg_ff),
      .first_is_reg     (s1_first_is_reg_ff),
      .second_is_reg    (s1_second_is_reg_ff),
      .third_is_reg     (s1_third_is_reg_ff),
      .second_is_offset (s1_second_is_offset_ff),
      .from_lo          (s1_from_lo_ff),
      .service_code     (s1_service_code_ff),
      .retire_index     (s1_retire_index_ff),
      .gpr_busy         (busy_ff),
      .lo_busy          (lo_cnt_ff != COUNT_ZERO),
      .hi_busy          (hi_cnt_ff != COUNT_ZERO),
      .upd              (upd)
   );

   // forward the last write; an idle register reads as zero
   assign gpr_raw = (fwd_valid_ff && (fwd_addr_ff == s1_upd_reg_ff)) ? fwd_data_ff : ram_rd_data;
   assign gpr_cnt = busy_ff[s1_upd_reg_ff] ? gpr_raw : COUNT_ZERO;
   assign gpr_new = count_step(gpr_cnt, upd.count_down);
   assign gpr_wr = process & upd.gpr_en;

   // next scoreboard state
   always_comb begin
      busy_in = busy_ff;
      lo_cnt_in = lo_cnt_ff;
      hi_cnt_in = hi_cnt_ff;
      if (gpr_wr) begin
         busy_in[s1_upd_reg_ff] = (gpr_new != COUNT_ZERO);
      end
      if (process && upd.lo_en) begin
         lo_cnt_in = count_step(lo_cnt_ff, upd.count_down);
      end
      if (process && upd.hi_en) begin
         hi_cnt_in = count_step(hi_cnt_ff, upd.count_down);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= '0;
         lo_cnt_ff <= COUNT_ZERO;
         hi_cnt_ff <= COUNT_ZERO;
         fwd_valid_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         lo_cnt_ff <= lo_cnt_in;
         hi_cnt_ff <= hi_cnt_in;
         if (gpr_wr) begin
            fwd_valid_ff <= 1'b1;
         end
      end
      if (gpr_wr) begin
         fwd_addr_ff <= s1_upd_reg_ff;
         fwd_data_ff <= gpr_new;
      end
   end

   // result register
   assign rsp_valid_in = advance ? s1_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (process) begin
         rsp_hazard_ff <= upd.hazard;
         rsp_fetch_stop_ff <= upd.fetch_stop;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_hazard = rsp_hazard_ff;
   assign rsp_fetch_stop = rsp_fetch_stop_ff;

   // a hazard never stops fetch
   `ISC_ASSERT(a_hazard_no_stop, rsp_valid_ff |-> !(rsp_hazard_ff && rsp_fetch_stop_ff), "hazard with fetch stop")
   // a hazard leaves every counter untouched
   `ISC_ASSERT(a_hazard_holds, (process && upd.hazard) |=> ($stable(busy_ff) && $stable(lo_cnt_ff) && $stable(hi_cnt_ff)), "hazard changed the scoreboard")
   // a retire reports neither hazard nor fetch stop
   `ISC_ASSERT(a_retire_quiet, (process && s1_kind_ff) |=> (!rsp_hazard_ff && !rsp_fetch_stop_ff), "retire reported a hazard")
   // reset empties both pipeline stages and the scoreboard
   `ISC_ASSERT_RST(a_reset_clear, reset |=> (!s1_valid_ff && !rsp_valid_ff && (busy_ff == '0)), "state left after reset")

endmodule
